// ===== rtl/core/xvsd_pkg.sv =====
// Shared constants, types and helpers for the XOR vertical span drawer.
// No dependencies; the top level, datapath and controller use this package.
`timescale 1ns / 1ps

package xvsd_pkg;

    // Framebuffer geometry
    localparam int COLUMNS          = 224;
    localparam int BYTES_PER_COLUMN = 32;
    localparam int FB_BYTES         = COLUMNS * BYTES_PER_COLUMN;
    localparam int ADDR_W           = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;

    // Field widths fixed by the interface
    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int BYTE_IDX_W = ROW_W - 3;
    localparam int DATA_W     = 8;

    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(BYTES_PER_COLUMN * 8 - 1);
    localparam logic [DATA_W-1:0] ALL_ONES  = 8'hff;
    localparam logic [2:0]        TOP_BIT   = 3'd7;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // latch a new span
        logic issue;       // read the current byte and advance
        logic clear_step;  // write one zero byte of the reset sweep
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic col_ok;      // column on the start port is on screen
        logic rd_last;     // current byte is the last of the span
        logic clear_last;  // sweep is at the final address
    } t_dp_status;

    // Saturate a row to the height of a column
    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] res;
        res = (row > ROW_MAX) ? ROW_MAX : row;
        return res;
    endfunction

endpackage

// ===== rtl/core/xor_vertical_span_drawer.sv =====
// Top level of the XOR vertical span drawer: controller plus datapath.
// Depends on xvsd_pkg, xvsd_ctrl, xvsd_dp (and xvsd_ram through the datapath).
`timescale 1ns / 1ps

// Inverts a vertical run of pixels in a column-major 1 bpp framebuffer
// (32 bytes per column, pixel y is bit y%8 of byte y/8) held in internal RAM.
// After reset the block sweeps the whole framebuffer to zero, one byte per
// cycle; busy stays high until all COLUMNS * BYTES_PER_COLUMN bytes are
// cleared and the first start word can be taken. A word is taken when
// start is high and busy is low. Rows above the column height saturate,
// reversed rows are swapped, and a column at or past COLUMNS is taken but
// draws nothing. For a span of n bytes (1..32) the block does one
// read-modify-write per byte, pipelined through the RAM's registered read
// port; busy stays high until the span's last result appears, so the next
// word cannot be taken before then. Results come out one per cycle in rising
// address order, each valid for exactly one cycle on o_valid; the receiver
// cannot stall, so it must take every word as it appears. The final word of
// a span has o_last_byte set. The last result appears in the cycle busy falls.

module xor_vertical_span_drawer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [xvsd_pkg::COL_W-1:0]     i_column,
    input  logic [xvsd_pkg::ROW_W-1:0]     i_row_first,
    input  logic [xvsd_pkg::ROW_W-1:0]     i_row_last,
    output logic                           o_valid,
    output logic [xvsd_pkg::ADDR_W-1:0]    o_byte_address,
    output logic [xvsd_pkg::DATA_W-1:0]    o_byte_value,
    output logic                           o_last_byte
);

    xvsd_pkg::t_dp_cmd    cmd;
    xvsd_pkg::t_dp_status status;

    xvsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    xvsd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_column       (i_column),
        .i_row_first    (i_row_first),
        .i_row_last     (i_row_last),
        .o_valid        (o_valid),
        .o_byte_address (o_byte_address),
        .o_byte_value   (o_byte_value),
        .o_last_byte    (o_last_byte)
    );

    // Span ends cleanly: nothing follows the last word directly.
    a_last_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |=> !o_valid)
        else $error("result word directly after last byte of span");

    // Bytes of one span come back to back at consecutive addresses.
    a_span_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_byte) |=>
            (o_valid && o_byte_address == xvsd_pkg::ADDR_W'($past(o_byte_address) + 1'b1)))
        else $error("span words not contiguous");

    // A freshly taken word cannot produce a result in the next cycle.
    a_accept_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result word too early after start");

endmodule

// ===== rtl/core/xvsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module xvsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/xvsd_dp.sv =====
// Datapath: span registers, byte read-modify-write pipe, reset sweep, result words.
// Depends on xvsd_pkg and xvsd_ram.
`timescale 1ns / 1ps

module xvsd_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  xvsd_pkg::t_dp_cmd              i_cmd,
    output xvsd_pkg::t_dp_status           o_status,
    input  logic [xvsd_pkg::COL_W-1:0]     i_column,
    input  logic [xvsd_pkg::ROW_W-1:0]     i_row_first,
    input  logic [xvsd_pkg::ROW_W-1:0]     i_row_last,
    output logic                           o_valid,
    output logic [xvsd_pkg::ADDR_W-1:0]    o_byte_address,
    output logic [xvsd_pkg::DATA_W-1:0]    o_byte_value,
    output logic                           o_last_byte
);

    // span registers
    logic [xvsd_pkg::ADDR_W-1:0]     r_base;
    logic [xvsd_pkg::ROW_W-1:0]      r_lo;
    logic [xvsd_pkg::ROW_W-1:0]      r_hi;
    logic [xvsd_pkg::BYTE_IDX_W-1:0] r_byte;

    // write stage (read data arrives here)
    logic                            r_wr_valid;
    logic [xvsd_pkg::ADDR_W-1:0]     r_wr_addr;
    logic [xvsd_pkg::DATA_W-1:0]     r_wr_mask;
    logic                            r_wr_last;

    // reset sweep
    logic [xvsd_pkg::ADDR_W-1:0]     r_clr_addr;

    // result word
    logic                            r_out_valid;
    logic [xvsd_pkg::ADDR_W-1:0]     r_out_addr;
    logic [xvsd_pkg::DATA_W-1:0]     r_out_value;
    logic                            r_out_last;

    logic [xvsd_pkg::ROW_W-1:0]      row_a;
    logic [xvsd_pkg::ROW_W-1:0]      row_b;
    logic [xvsd_pkg::ADDR_W-1:0]     rd_addr;
    logic                            is_first;
    logic                            is_last;
    logic [2:0]                      lo_bit;
    logic [2:0]                      hi_bit;
    logic [xvsd_pkg::DATA_W-1:0]     mask;
    logic [xvsd_pkg::DATA_W-1:0]     rd_data;
    logic [xvsd_pkg::DATA_W-1:0]     new_value;
    logic                            ram_we;
    logic [xvsd_pkg::ADDR_W-1:0]     ram_waddr;
    logic [xvsd_pkg::DATA_W-1:0]     ram_wdata;

    assign row_a = xvsd_pkg::clamp_row(i_row_first);
    assign row_b = xvsd_pkg::clamp_row(i_row_last);

    assign rd_addr  = r_base + xvsd_pkg::ADDR_W'(r_byte);
    assign is_first = (r_byte == r_lo[xvsd_pkg::ROW_W-1:3]);
    assign is_last  = (r_byte == r_hi[xvsd_pkg::ROW_W-1:3]);
    assign lo_bit   = is_first ? r_lo[2:0] : 3'd0;
    assign hi_bit   = is_last  ? r_hi[2:0] : xvsd_pkg::TOP_BIT;
    assign mask     = (xvsd_pkg::ALL_ONES << lo_bit)
                    & (xvsd_pkg::ALL_ONES >> (xvsd_pkg::TOP_BIT - hi_bit));

    assign new_value = rd_data ^ r_wr_mask;

    // sweep and RMW never overlap
    assign ram_we    = i_cmd.clear_step | r_wr_valid;
    assign ram_waddr = i_cmd.clear_step ? r_clr_addr : r_wr_addr;
    assign ram_wdata = i_cmd.clear_step ? '0 : new_value;

    xvsd_ram #(
        .WIDTH (xvsd_pkg::DATA_W),
        .DEPTH (xvsd_pkg::FB_BYTES)
    ) u_fb (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= xvsd_pkg::ADDR_W'(i_column)
                    * xvsd_pkg::ADDR_W'(xvsd_pkg::BYTES_PER_COLUMN);
            if (row_a > row_b) begin
                r_lo   <= row_b;
                r_hi   <= row_a;
                r_byte <= row_b[xvsd_pkg::ROW_W-1:3];
            end else begin
                r_lo   <= row_a;
                r_hi   <= row_b;
                r_byte <= row_a[xvsd_pkg::ROW_W-1:3];
            end
        end else if (i_cmd.issue) begin
            r_byte <= r_byte + 1'b1;
        end
        if (i_cmd.issue) begin
            r_wr_addr <= rd_addr;
            r_wr_mask <= mask;
            r_wr_last <= is_last;
        end
        if (r_wr_valid) begin
            r_out_addr  <= r_wr_addr;
            r_out_value <= new_value;
            r_out_last  <= r_wr_last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_wr_valid  <= i_cmd.issue;
            r_out_valid <= r_wr_valid;
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_status.col_ok     = (int'(i_column) < xvsd_pkg::COLUMNS);
    assign o_status.rd_last    = is_last;
    assign o_status.clear_last = (r_clr_addr == xvsd_pkg::ADDR_W'(xvsd_pkg::FB_BYTES - 1));

    assign o_valid        = r_out_valid;
    assign o_byte_address = r_out_addr;
    assign o_byte_value   = r_out_value;
    assign o_last_byte    = r_out_last;

endmodule

// ===== rtl/core/xvsd_ctrl.sv =====
// Controller: sequences the reset sweep and the byte loop of each span.
// Depends on xvsd_pkg.
`timescale 1ns / 1ps

module xvsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  xvsd_pkg::t_dp_status  i_status,
    output xvsd_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // off-screen column: word taken, nothing drawn
                if (i_start && i_status.col_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule
